// ===== sv/nk_landscape_fitness_eval_top_assert.svh =====
// ----------------------------------------------------------------------------
// nk landscape fitness evaluator assertion macros
// concurrent checks clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef NK_LANDSCAPE_FITNESS_EVAL_TOP_ASSERT_SVH
`define NK_LANDSCAPE_FITNESS_EVAL_TOP_ASSERT_SVH

// property checked at every rising edge outside reset
`define NKFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define NKFE_ASSERT_IMPL(lbl, ante, cons, msg) \
	`NKFE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== sv/nkfe_pkg.sv =====
// ----------------------------------------------------------------------------
// nkfe_pkg
// shared constants and codes of the nk landscape fitness evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package nkfe_pkg;

	// number of loci in a genotype
	localparam int unsigned LOCI = 8;

	// item field widths
	localparam int unsigned OPCODE_W  = 2;
	localparam int unsigned ROW_W     = 8;
	localparam int unsigned LOCUS_W   = 3;
	localparam int unsigned CONTRIB_W = 16;
	localparam int unsigned MASK_W    = 8;
	localparam int unsigned GENO_W    = 8;
	localparam int unsigned FIT_W     = 16;

	// packed stream widths, rounded up to whole bytes
	localparam int unsigned IN_BITS  = OPCODE_W + ROW_W + LOCUS_W + CONTRIB_W + MASK_W + GENO_W;
	localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_TDATA_W = ((FIT_W + 7) / 8) * 8;

	// table geometry: row index concatenated with column index
	localparam int unsigned COL_W     = $clog2(LOCI);
	localparam int unsigned ADDR_W    = LOCI + COL_W;
	localparam int unsigned TBL_DEPTH = 2 ** ADDR_W;

	// sum of LOCI contributions and exact division by LOCI via reciprocal
	localparam int unsigned SUM_W       = CONTRIB_W + COL_W;
	localparam int unsigned RECIP_SHIFT = SUM_W + COL_W;
	localparam int unsigned RECIP_W     = SUM_W + 1;
	localparam int unsigned RECIP       = ((2 ** RECIP_SHIFT) + LOCI - 1) / LOCI;
	localparam int unsigned PROD_W      = SUM_W + RECIP_W;

	// item opcodes
	typedef enum logic [OPCODE_W-1:0] {
		OP_WR_TABLE = 2'd0,
		OP_WR_MASK  = 2'd1,
		OP_EVAL     = 2'd2
	} opcode_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_LAST = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

endpackage

`default_nettype wire

// ===== sv/nk_landscape_fitness_eval_top.sv =====
// ----------------------------------------------------------------------------
// nk_landscape_fitness_eval_top
// nk landscape fitness evaluator: table and mask loading, iterative evaluation
// ----------------------------------------------------------------------------
// usage
//   s_* carries one item per handshake: a table write, a mask write or an
//   evaluate command. writes complete in the accepting cycle and give no result.
//   an evaluate item makes one fitness result on m_*, the mean of the LOCI
//   table contributions picked by genotype AND mask of each locus.
// datapath
//   one table read per locus through a table memory with a registered read
//   port and a shared accumulator adder, then one reciprocal multiply for the
//   division by LOCI. after an evaluate item, the next item is taken only once
//   its result is in the output register; write items are taken every cycle
//   while no evaluation is in progress.
// reset and stall
//   arst_n clears the sequencer and the output valid; table and masks keep
//   undefined contents until written. while a result waits for m_tready the
//   block still takes write items, and the next evaluation holds in its
//   divide step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nk_landscape_fitness_eval_top_assert.svh"

module nk_landscape_fitness_eval_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// opcode, table_row, locus, contribution, mask_bits, genotype, zero fill
	input  wire logic [nkfe_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// fitness
	output logic [nkfe_pkg::OUT_TDATA_W-1:0]         m_tdata
);

	// input field unpacking
	localparam int unsigned OP_LO   = 0;
	localparam int unsigned ROW_LO  = OP_LO + nkfe_pkg::OPCODE_W;
	localparam int unsigned LOC_LO  = ROW_LO + nkfe_pkg::ROW_W;
	localparam int unsigned CON_LO  = LOC_LO + nkfe_pkg::LOCUS_W;
	localparam int unsigned MSK_LO  = CON_LO + nkfe_pkg::CONTRIB_W;
	localparam int unsigned GEN_LO  = MSK_LO + nkfe_pkg::MASK_W;

	localparam logic [nkfe_pkg::COL_W-1:0] LAST_COL = nkfe_pkg::COL_W'(nkfe_pkg::LOCI - 1);
	localparam logic [nkfe_pkg::RECIP_W-1:0] RECIP_C =
		nkfe_pkg::RECIP_W'(nkfe_pkg::RECIP);

	nkfe_pkg::opcode_t                 in_op;
	logic [nkfe_pkg::ROW_W-1:0]        in_row;
	logic [nkfe_pkg::LOCUS_W-1:0]      in_locus;
	logic [nkfe_pkg::CONTRIB_W-1:0]    in_contrib;
	logic [nkfe_pkg::MASK_W-1:0]       in_mask;
	logic [nkfe_pkg::GENO_W-1:0]       in_geno;
	logic                              in_acc;
	logic                              locus_ok;

	assign in_op      = nkfe_pkg::opcode_t'(s_tdata[OP_LO +: nkfe_pkg::OPCODE_W]);
	assign in_row     = s_tdata[ROW_LO +: nkfe_pkg::ROW_W];
	assign in_locus   = s_tdata[LOC_LO +: nkfe_pkg::LOCUS_W];
	assign in_contrib = s_tdata[CON_LO +: nkfe_pkg::CONTRIB_W];
	assign in_mask    = s_tdata[MSK_LO +: nkfe_pkg::MASK_W];
	assign in_geno    = s_tdata[GEN_LO +: nkfe_pkg::GENO_W];
	assign in_acc     = s_tvalid && s_tready;
	assign locus_ok   = 32'(in_locus) < 32'(nkfe_pkg::LOCI);

	// storage, contents undefined until written
	logic [nkfe_pkg::CONTRIB_W-1:0] table_mem [nkfe_pkg::TBL_DEPTH];
	logic [nkfe_pkg::MASK_W-1:0]    mask_q    [nkfe_pkg::LOCI];

	// sequencer and datapath registers
	nkfe_pkg::state_t               state_q;
	logic [nkfe_pkg::COL_W-1:0]     col_q;
	logic [nkfe_pkg::LOCI-1:0]      geno_q;
	logic [nkfe_pkg::SUM_W-1:0]     acc_q;
	logic [nkfe_pkg::CONTRIB_W-1:0] rd_data_q;
	logic [nkfe_pkg::FIT_W-1:0]     fit_q;
	logic                           out_valid_q;

	logic [nkfe_pkg::ADDR_W-1:0]    wr_addr;
	logic [nkfe_pkg::ADDR_W-1:0]    rd_addr;
	logic [nkfe_pkg::LOCI-1:0]      rd_row;
	logic                           acc_en;
	logic [nkfe_pkg::SUM_W-1:0]     acc_sum;
	logic [nkfe_pkg::PROD_W-1:0]    prod;
	logic                           out_free;

	assign s_tready = (state_q == nkfe_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = nkfe_pkg::OUT_TDATA_W'(fit_q);
	assign out_free = !out_valid_q || m_tready;

	// table addressing: row bits above column bits
	assign wr_addr = {nkfe_pkg::LOCI'(in_row), nkfe_pkg::COL_W'(in_locus)};
	assign rd_row  = geno_q & nkfe_pkg::LOCI'(mask_q[col_q]);
	assign rd_addr = {rd_row, col_q};

	// shared accumulator adder, fed one registered table read per cycle
	assign acc_en  = ((state_q == nkfe_pkg::ST_READ) && (col_q != '0))
		|| (state_q == nkfe_pkg::ST_LAST);
	assign acc_sum = acc_q + nkfe_pkg::SUM_W'(rd_data_q);

	// exact floor division by LOCI through reciprocal multiply
	assign prod = nkfe_pkg::PROD_W'(acc_q) * nkfe_pkg::PROD_W'(RECIP_C);

	// table memory: write port on accepted items, registered read port
	always_ff @(posedge clk) begin
		if (in_acc && (in_op == nkfe_pkg::OP_WR_TABLE) && locus_ok) begin
			table_mem[wr_addr] <= in_contrib;
		end
		rd_data_q <= table_mem[rd_addr];
	end

	// interaction masks
	always_ff @(posedge clk) begin
		if (in_acc && (in_op == nkfe_pkg::OP_WR_MASK) && locus_ok) begin
			mask_q[nkfe_pkg::COL_W'(in_locus)] <= in_mask;
		end
	end

	// evaluation payload registers
	always_ff @(posedge clk) begin
		if (in_acc && (in_op == nkfe_pkg::OP_EVAL)) begin
			geno_q <= nkfe_pkg::LOCI'(in_geno);
			acc_q  <= '0;
		end else if (acc_en) begin
			acc_q  <= acc_sum;
		end
		if ((state_q == nkfe_pkg::ST_DIV) && out_free) begin
			fit_q <= prod[nkfe_pkg::RECIP_SHIFT +: nkfe_pkg::FIT_W];
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nkfe_pkg::ST_IDLE;
			col_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// valid set when the divide step completes, cleared when taken
			if ((state_q == nkfe_pkg::ST_DIV) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				nkfe_pkg::ST_IDLE: begin
					if (in_acc && (in_op == nkfe_pkg::OP_EVAL)) begin
						state_q <= nkfe_pkg::ST_READ;
						col_q   <= '0;
					end
				end
				nkfe_pkg::ST_READ: begin
					if (col_q == LAST_COL) begin
						state_q <= nkfe_pkg::ST_LAST;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				nkfe_pkg::ST_LAST: begin
					state_q <= nkfe_pkg::ST_DIV;
				end
				nkfe_pkg::ST_DIV: begin
					if (out_free) begin
						state_q <= nkfe_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= nkfe_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// short names for the checks
	logic busy;
	logic st_read;
	logic st_div;
	logic eval_acc;

	assign busy     = (state_q != nkfe_pkg::ST_IDLE);
	assign st_read  = (state_q == nkfe_pkg::ST_READ);
	assign st_div   = (state_q == nkfe_pkg::ST_DIV);
	assign eval_acc = in_acc && (in_op == nkfe_pkg::OP_EVAL);

	// checks
	`NKFE_ASSERT_IMPL(a_busy_not_ready, busy, !s_tready, "input ready while busy")
	`NKFE_ASSERT_IMPL(a_col_range, st_read, col_q <= LAST_COL, "locus counter out of range")
	`NKFE_ASSERT(a_eval_starts, eval_acc |=> (st_read && (col_q == '0)), "evaluation did not start")
	`NKFE_ASSERT_IMPL(a_result_source, $rose(m_tvalid), $past(st_div), "result without divide step")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nk landscape fitness evaluator testbench
// drives table writes, mask writes, evaluations and unused opcodes on the
// input stream, predicts each fitness from a shadow copy of table and masks,
// and checks the output stream in order under idle, stall and hold-off phases
// ----------------------------------------------------------------------------

module testbench;

	localparam logic [nkfe_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned ROWS          = 1 << nkfe_pkg::LOCI;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned PHASE_ITEMS   = 256;
	localparam int unsigned DRAIN_LIMIT   = 20000;

	// one input item, first field in the lowest bits
	typedef struct packed {
		logic [nkfe_pkg::IN_TDATA_W-nkfe_pkg::IN_BITS-1:0] fill;
		logic [nkfe_pkg::GENO_W-1:0]                       genotype;
		logic [nkfe_pkg::MASK_W-1:0]                       mask_bits;
		logic [nkfe_pkg::CONTRIB_W-1:0]                    contribution;
		logic [nkfe_pkg::LOCUS_W-1:0]                      locus;
		logic [nkfe_pkg::ROW_W-1:0]                        table_row;
		logic [nkfe_pkg::OPCODE_W-1:0]                     opcode;
	} nk_item_t;

	// shadow of the evaluator and queue of fitness values still to come
	class fitness_scoreboard;
		logic [nkfe_pkg::CONTRIB_W-1:0] contrib_tbl [ROWS][nkfe_pkg::LOCI];
		logic [nkfe_pkg::MASK_W-1:0]    locus_mask  [nkfe_pkg::LOCI];
		logic [nkfe_pkg::FIT_W-1:0]     pending_fitness [$];
		int n_errors  = 0;
		int n_checked = 0;

		task report_mismatch(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			n_errors++;
		endtask

		function void note_item(nk_item_t it);
			logic [nkfe_pkg::LOCI-1:0]  row;
			logic [nkfe_pkg::LOCI-1:0]  idx;
			logic [nkfe_pkg::COL_W-1:0] col;
			int unsigned                sum;
			row = nkfe_pkg::LOCI'(it.table_row);
			col = nkfe_pkg::COL_W'(it.locus);
			case (it.opcode)
				nkfe_pkg::OP_WR_TABLE: begin
					if (32'(it.locus) < nkfe_pkg::LOCI)
						contrib_tbl[row][col] = it.contribution;
				end
				nkfe_pkg::OP_WR_MASK: begin
					if (32'(it.locus) < nkfe_pkg::LOCI)
						locus_mask[col] = it.mask_bits;
				end
				nkfe_pkg::OP_EVAL: begin
					sum = 0;
					for (int j = 0; j < nkfe_pkg::LOCI; j++) begin
						col = nkfe_pkg::COL_W'(j);
						idx = nkfe_pkg::LOCI'(it.genotype)
							& nkfe_pkg::LOCI'(locus_mask[col]);
						sum += 32'(contrib_tbl[idx][col]);
					end
					pending_fitness.insert(pending_fitness.size(),
						nkfe_pkg::FIT_W'(sum / nkfe_pkg::LOCI));
				end
				default: ;
			endcase
		endfunction

		task check_fitness(logic [nkfe_pkg::FIT_W-1:0] got);
			logic [nkfe_pkg::FIT_W-1:0] want;
			if (pending_fitness.size() == 0) begin
				report_mismatch($sformatf("fitness %h with nothing outstanding", got));
			end else begin
				want = pending_fitness.pop_front();
				n_checked++;
				if (got !== want)
					report_mismatch($sformatf("fitness %h, predicted %h", got, want));
			end
		endtask

		function int pending();
			return pending_fitness.size();
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [nkfe_pkg::IN_TDATA_W-1:0] s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [nkfe_pkg::OUT_TDATA_W-1:0] m_tdata;

	fitness_scoreboard sb = new;

	// stimulus-side view of what has been written so far
	bit                          gen_written [ROWS][nkfe_pkg::LOCI];
	logic [nkfe_pkg::MASK_W-1:0] gen_mask [nkfe_pkg::LOCI];

	int  tx_idle_pct  = 0;
	int  rx_stall_pct = 0;
	bit  hold_rx      = 0;
	int  n_fed        = 0;
	int  n_evals      = 0;
	int  n_tbl_wr     = 0;
	int  n_mask_wr    = 0;
	int  n_unused     = 0;
	int  n_holds      = 0;

	nk_landscape_fitness_eval_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	// handshake monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_fitness(m_tdata[nkfe_pkg::FIT_W-1:0]);
		if (arst_n && s_tvalid && s_tready)
			sb.note_item(nk_item_t'(s_tdata));
	end

	// result receiver: random stalls, or a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 0;
				n_holds++;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// offer one item, with a random gap first, and wait until it is taken
	task automatic send_item(nk_item_t it);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it;
		do @(posedge clk); while (!s_tready);
	endtask

	// all fields random, so unused fields toggle too
	function automatic nk_item_t noise_item();
		nk_item_t it;
		it = '0;
		it.opcode       = nkfe_pkg::OPCODE_W'($urandom);
		it.table_row    = nkfe_pkg::ROW_W'($urandom);
		it.locus        = nkfe_pkg::LOCUS_W'($urandom);
		it.contribution = nkfe_pkg::CONTRIB_W'($urandom);
		it.mask_bits    = nkfe_pkg::MASK_W'($urandom);
		it.genotype     = nkfe_pkg::GENO_W'($urandom);
		return it;
	endfunction

	function automatic logic [nkfe_pkg::CONTRIB_W-1:0] rand_contrib();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return nkfe_pkg::CONTRIB_W'($urandom);
		endcase
	endfunction

	task automatic put_table(int unsigned row, int unsigned col,
		logic [nkfe_pkg::CONTRIB_W-1:0] v);
		nk_item_t it;
		it = noise_item();
		it.opcode       = nkfe_pkg::OP_WR_TABLE;
		it.table_row    = nkfe_pkg::ROW_W'(row);
		it.locus        = nkfe_pkg::LOCUS_W'(col);
		it.contribution = v;
		gen_written[nkfe_pkg::LOCI'(row)][nkfe_pkg::COL_W'(col)] = 1'b1;
		n_fed++;
		n_tbl_wr++;
		send_item(it);
	endtask

	task automatic put_mask(int unsigned col, logic [nkfe_pkg::MASK_W-1:0] m);
		nk_item_t it;
		it = noise_item();
		it.opcode    = nkfe_pkg::OP_WR_MASK;
		it.locus     = nkfe_pkg::LOCUS_W'(col);
		it.mask_bits = m;
		gen_mask[nkfe_pkg::COL_W'(col)] = m;
		n_fed++;
		n_mask_wr++;
		send_item(it);
	endtask

	// evaluation, preceded by writes of any entry it would read unwritten
	task automatic put_eval(logic [nkfe_pkg::GENO_W-1:0] g);
		nk_item_t                   it;
		logic [nkfe_pkg::LOCI-1:0]  idx;
		logic [nkfe_pkg::COL_W-1:0] col;
		for (int j = 0; j < nkfe_pkg::LOCI; j++) begin
			col = nkfe_pkg::COL_W'(j);
			idx = nkfe_pkg::LOCI'(g) & nkfe_pkg::LOCI'(gen_mask[col]);
			if (!gen_written[idx][col])
				put_table(32'(idx), 32'(col), rand_contrib());
		end
		it = noise_item();
		it.opcode   = nkfe_pkg::OP_EVAL;
		it.genotype = g;
		n_fed++;
		n_evals++;
		send_item(it);
	endtask

	task automatic put_unused();
		nk_item_t it;
		it = noise_item();
		it.opcode = OP_UNUSED;
		n_unused++;
		send_item(it);
	endtask

	task automatic random_item();
		int unsigned                 pick;
		logic [nkfe_pkg::MASK_W-1:0] m;
		pick = $urandom_range(99);
		if (pick < 70) begin
			put_eval(nkfe_pkg::GENO_W'($urandom));
		end else if (pick < 82) begin
			put_table($urandom_range(ROWS - 1), $urandom_range(nkfe_pkg::LOCI - 1),
				rand_contrib());
		end else if (pick < 92) begin
			case ($urandom_range(5))
				0:       m = '0;
				1:       m = '1;
				default: m = nkfe_pkg::MASK_W'($urandom);
			endcase
			put_mask($urandom_range(nkfe_pkg::LOCI - 1), m);
		end else begin
			put_unused();
		end
	endtask

	task automatic run_phase(int tx_pct, int rx_pct);
		int target;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		target = n_fed + PHASE_ITEMS;
		while (n_fed < target)
			random_item();
	endtask

	// main sequence
	initial begin
		int guard;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cleared masks, full-scale contributions, unused opcode
		for (int j = 0; j < nkfe_pkg::LOCI; j++)
			put_mask(j, '0);
		for (int j = 0; j < nkfe_pkg::LOCI; j++)
			put_table(0, j, '1);
		put_eval('1);
		put_unused();
		put_table(0, 0, '0);
		put_eval('0);
		put_mask(nkfe_pkg::LOCI - 1, '1);
		put_table(ROWS - 1, nkfe_pkg::LOCI - 1, 16'h8001);
		put_eval('1);
		put_eval(8'h80);

		// random phases
		run_phase(0, 0);
		run_phase(58, 0);
		run_phase(0, 58);
		run_phase(27, 27);

		// receiver holds off while items keep coming
		hold_rx = 1;
		run_phase(0, 0);
		s_tvalid <= 1'b0;

		// drain
		guard = 0;
		while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (sb.pending() != 0) begin
			$display("%0d fitness results never arrived", sb.pending());
			$display("testbench failed");
			$finish;
		end else begin
			repeat (nkfe_pkg::LOCI + 8) @(posedge clk);
			$display("sent %0d evaluations, %0d table writes, %0d mask writes, %0d unused",
				n_evals, n_tbl_wr, n_mask_wr, n_unused);
			$display("checked %0d fitness results over idle, stall and %0d hold-off phases",
				sb.n_checked, n_holds);
			if (sb.n_errors == 0)
				$display("testbench passed");
			else
				$display("testbench failed");
			$finish;
		end
	end

endmodule
